@@ sv/key_debounce_shortpress_combo_macros.svh @@
// Assertion macros for the key debounce block.
`ifndef KEY_DEBOUNCE_SHORTPRESS_COMBO_MACROS_SVH
`define KEY_DEBOUNCE_SHORTPRESS_COMBO_MACROS_SVH

`ifndef SYNTH
`define KDSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("kdsc: assertion failed");
`define KDSC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("kdsc: forbidden condition seen");
`else
`define KDSC_ASSERT(lbl, prop)
`define KDSC_ASSERT_NEVER(lbl, cond)
`endif

`endif

@@ sv/kdsc_pkg.sv @@
package kdsc_pkg;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_RD_STABLE = 3'd1,
    CMD_RD_SHORT  = 3'd2,
    CMD_RD_CUR    = 3'd3,
    CMD_CHECK     = 3'd4
  } kdsc_cmd_e;

  typedef enum logic [2:0] {
    REG_DEBOUNCE  = 3'd0,
    REG_PWR_DEB   = 3'd1,
    REG_LVL_ONE   = 3'd2,
    REG_LVL_TWO   = 3'd3,
    REG_LVL_THREE = 3'd4,
    REG_LVL_FOUR  = 3'd5,
    REG_WINDOW    = 3'd6,
    REG_TIMEOUT   = 3'd7
  } kdsc_reg_e;

  // level / state codes
  localparam logic [1:0] LVL_LOW  = 2'd0;
  localparam logic [1:0] LVL_HIGH = 2'd1;
  localparam logic [1:0] LVL_NONE = 2'd2;

  // result codes
  localparam logic [1:0] ST_OFF  = 2'd0;
  localparam logic [1:0] ST_ON   = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  localparam int unsigned POWER_KEY    = 3;
  localparam int unsigned FIRST_LADDER = 4;
  localparam int unsigned NUM_LADDER   = 4;

  // active level per key: ir, door, power high; wall and ladder low
  localparam logic [7:0] ACT_LVL = 8'b0000_1101;

  // K1 K2 K3 K4 K1 K4 K3 K2
  localparam logic [3:0] CODE_SEQ [8] = '{4'd4, 4'd5, 4'd6, 4'd7, 4'd4, 4'd7, 4'd6, 4'd5};

  localparam logic [7:0]  DEBOUNCE_RST = 8'd20;
  localparam logic [7:0]  PWR_DEB_RST  = 8'd5;
  localparam logic [7:0]  LVL_ONE_RST  = 8'd32;
  localparam logic [7:0]  LVL_TWO_RST  = 8'd96;
  localparam logic [7:0]  LVL_THR_RST  = 8'd160;
  localparam logic [7:0]  LVL_FOUR_RST = 8'd224;
  localparam logic [6:0]  WINDOW_RST   = 7'd16;
  localparam logic [15:0] TIMEOUT_RST  = 16'd500;

  typedef struct packed {
    logic       tick;
    logic       sample;
    logic       act;
    logic [7:0] limit;
    logic       clr_stat;
    logic       clr_sp;
  } kdsc_key_ctl_t;

  typedef struct packed {
    logic [1:0] cur;
    logic [1:0] stat;
    logic [1:0] sp;
    logic       press;
  } kdsc_key_sts_t;

endpackage

@@ sv/kdsc_intf.sv @@
interface kdsc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [2:0] key_id;
  logic       pin_ir;
  logic       pin_wall;
  logic       pin_door;
  logic       pin_power;
  logic [7:0] adc_sample;

  modport source (output valid, cmd, key_id, pin_ir, pin_wall, pin_door, pin_power,
                  adc_sample, input ready);
  modport sink (input valid, cmd, key_id, pin_ir, pin_wall, pin_door, pin_power,
                adc_sample, output ready);
endinterface

interface kdsc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;

  modport source (output valid, status, input ready);
  modport sink (input valid, status, output ready);
endinterface

interface kdsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_idx;
  logic [15:0] wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink (input valid, reg_idx, wdata, output ready);
endinterface

@@ sv/kdsc_key.sv @@
module kdsc_key #(
  parameter int unsigned SHORT_PRESS_LIMIT = 500
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kdsc_pkg::kdsc_key_ctl_t ctl_i,
  output kdsc_pkg::kdsc_key_sts_t sts_o
);
  import kdsc_pkg::*;

  localparam int unsigned DUR_W = $clog2(SHORT_PRESS_LIMIT + 1);
  localparam logic [DUR_W-1:0] DUR_MAX = DUR_W'(SHORT_PRESS_LIMIT);

  logic [1:0]       cur_q, cur_d;
  logic [1:0]       stat_q, stat_d;
  logic [1:0]       sp_q, sp_d;
  logic [7:0]       cnt_q, cnt_d;
  logic [DUR_W-1:0] dur_q, dur_d;
  logic [1:0]       samp;
  logic             press;

  assign samp = {1'b0, ctl_i.sample};

  always_comb begin
    cur_d  = cur_q;
    stat_d = stat_q;
    sp_d   = sp_q;
    cnt_d  = cnt_q;
    dur_d  = dur_q;
    press  = 1'b0;
    if (ctl_i.tick) begin
      cur_d = samp;
      if (sp_q == LVL_LOW) begin
        if (dur_q < DUR_MAX) begin
          dur_d = dur_q + 1'b1;
        end else begin
          sp_d = LVL_NONE;
        end
      end
      if (samp != cur_q) begin
        cnt_d  = '0;
        stat_d = LVL_NONE;
      end else if (cnt_q < ctl_i.limit) begin
        cnt_d = cnt_q + 8'd1;
      end else if (cnt_q == ctl_i.limit) begin
        stat_d = samp;
        cnt_d  = cnt_q + 8'd1;
        if (ctl_i.sample == ctl_i.act) begin
          press = 1'b1;
          dur_d = '0;
          sp_d  = LVL_LOW;
        end else if (dur_d < DUR_MAX && sp_d == LVL_LOW) begin
          sp_d = LVL_HIGH;
        end
      end
    end else begin
      if (ctl_i.clr_stat) begin
        stat_d = LVL_NONE;
      end
      if (ctl_i.clr_sp) begin
        sp_d = LVL_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= LVL_NONE;
      stat_q <= LVL_NONE;
      sp_q   <= LVL_NONE;
      cnt_q  <= '0;
      dur_q  <= '0;
    end else begin
      cur_q  <= cur_d;
      stat_q <= stat_d;
      sp_q   <= sp_d;
      cnt_q  <= cnt_d;
      dur_q  <= dur_d;
    end
  end

  assign sts_o = '{cur: cur_q, stat: stat_q, sp: sp_q, press: press};

endmodule

@@ sv/key_debounce_shortpress_combo.sv @@
// Key debounce with resistor-ladder decode and combination code.
//
// in_i  : one item per command (tick, read stable, read short press, read
//         current, check code) with key id, four pin levels and an ADC value.
// res_o : one status item for every accepted item, in order.
// cfg_i : register writes (index 0..7), always ready; write only while idle.
//
// An accepted item lands in an input register; it is then executed, once the
// result register is free or being taken, against the key state and its status
// is loaded into the result register, which drives res_o.valid. Throughput is
// one item per cycle while res_o takes results, set by the single execute
// stage where all keys update in parallel.
// When res_o stalls, one more item is held in the input register and in_i
// drops ready only once both registers are full.
//
// Reset loads register defaults, puts every key in the none state, empties
// the press history and loads the history timer with the default timeout.
`include "key_debounce_shortpress_combo_macros.svh"

module key_debounce_shortpress_combo #(
  parameter int unsigned NUM_KEYS          = 8,
  parameter int unsigned CODE_LENGTH       = 8,
  parameter int unsigned SHORT_PRESS_LIMIT = 500
) (
  input logic        clk_i,
  input logic        rst_ni,
  kdsc_in_if.sink    in_i,
  kdsc_out_if.source res_o,
  kdsc_cfg_if.sink   cfg_i
);
  import kdsc_pkg::*;

  localparam int unsigned KEY_W  = $clog2(NUM_KEYS);
  localparam int unsigned KEY_CW = 5;

  // configuration
  logic [7:0]  deb_q, pwr_q;
  logic [7:0]  lvl_q [NUM_LADDER];
  logic [6:0]  win_q;
  logic [15:0] tmo_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q    <= DEBOUNCE_RST;
      pwr_q    <= PWR_DEB_RST;
      lvl_q[0] <= LVL_ONE_RST;
      lvl_q[1] <= LVL_TWO_RST;
      lvl_q[2] <= LVL_THR_RST;
      lvl_q[3] <= LVL_FOUR_RST;
      win_q    <= WINDOW_RST;
      tmo_q    <= TIMEOUT_RST;
    end else if (cfg_i.valid) begin
      case (kdsc_reg_e'(cfg_i.reg_idx))
        REG_DEBOUNCE:  deb_q    <= cfg_i.wdata[7:0];
        REG_PWR_DEB:   pwr_q    <= cfg_i.wdata[7:0];
        REG_LVL_ONE:   lvl_q[0] <= cfg_i.wdata[7:0];
        REG_LVL_TWO:   lvl_q[1] <= cfg_i.wdata[7:0];
        REG_LVL_THREE: lvl_q[2] <= cfg_i.wdata[7:0];
        REG_LVL_FOUR:  lvl_q[3] <= cfg_i.wdata[7:0];
        REG_WINDOW:    win_q    <= cfg_i.wdata[6:0];
        REG_TIMEOUT:   tmo_q    <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // input register
  logic       s1_valid_q;
  logic [2:0] s1_cmd_q, s1_key_q;
  logic [3:0] s1_pins_q;
  logic [7:0] s1_adc_q;
  logic       out_valid_q;
  logic [1:0] out_status_q, status_d;
  logic       exec;

  assign exec       = s1_valid_q && (!out_valid_q || res_o.ready);
  assign in_i.ready = !s1_valid_q || exec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        s1_valid_q <= 1'b1;
      end else if (exec) begin
        s1_valid_q <= 1'b0;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_cmd_q  <= in_i.cmd;
      s1_key_q  <= in_i.key_id;
      s1_pins_q <= {in_i.pin_power, in_i.pin_door, in_i.pin_wall, in_i.pin_ir};
      s1_adc_q  <= in_i.adc_sample;
    end
    if (exec) begin
      out_status_q <= status_d;
    end
  end

  assign res_o.valid  = out_valid_q;
  assign res_o.status = out_status_q;

  // ladder decode, first window wins
  logic [NUM_LADDER-1:0] lad_hit, lad_first;

  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int j = 0; j < NUM_LADDER; j++) begin
      lad_hit[j] = ({1'b0, s1_adc_q} + {2'b0, win_q} >= {1'b0, lvl_q[j]}) &&
                   ({1'b0, s1_adc_q} <= {1'b0, lvl_q[j]} + {2'b0, win_q});
      lad_first[j] = lad_hit[j] && !seen;
      seen = seen | lad_hit[j];
    end
  end

  // command decode
  logic            is_tick, key_ok;
  logic [KEY_W-1:0] key_idx;
  kdsc_cmd_e       cmd;

  assign cmd     = kdsc_cmd_e'(s1_cmd_q);
  assign is_tick = exec && (cmd == CMD_TICK);
  assign key_ok  = KEY_CW'(s1_key_q) < KEY_CW'(NUM_KEYS);
  assign key_idx = KEY_W'(s1_key_q);

  // keys
  kdsc_key_sts_t          key_sts [NUM_KEYS];
  logic [NUM_KEYS-1:0]   act_vec;
  logic [NUM_LADDER-1:0] push_vec;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    kdsc_key_ctl_t ctl;
    logic          samp;
    logic          sel;

    if (k < FIRST_LADDER) begin : g_pin
      assign samp       = s1_pins_q[k];
      assign act_vec[k] = ACT_LVL[k];
    end else if (k < FIRST_LADDER + NUM_LADDER) begin : g_lad
      assign samp                        = ~lad_first[k - FIRST_LADDER];
      assign act_vec[k]                  = ACT_LVL[k];
      assign push_vec[k - FIRST_LADDER]  = key_sts[k].press;
    end else begin : g_extra
      assign samp       = 1'b1;
      assign act_vec[k] = 1'b0;
    end

    assign sel = exec && key_ok && (key_idx == KEY_W'(k));
    assign ctl = '{
      tick:     is_tick,
      sample:   samp,
      act:      act_vec[k],
      limit:    (k == POWER_KEY) ? pwr_q : deb_q,
      clr_stat: sel && (cmd == CMD_RD_STABLE),
      clr_sp:   sel && (cmd == CMD_RD_SHORT) && (key_sts[k].sp == LVL_HIGH)
    };

    kdsc_key #(
      .SHORT_PRESS_LIMIT(SHORT_PRESS_LIMIT)
    ) u_key (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl),
      .sts_o (key_sts[k])
    );
  end

  for (genvar j = 0; j < NUM_LADDER; j++) begin : g_nopush
    if (FIRST_LADDER + j >= NUM_KEYS) begin : g_tie
      assign push_vec[j] = 1'b0;
    end
  end

  // press history
  logic [3:0]             hist_q [CODE_LENGTH];
  logic [3:0]             hist_d [CODE_LENGTH];
  logic [CODE_LENGTH-1:0] hist_vld_q, hist_vld_d;
  logic [15:0]            timer_q, timer_d, timer_sel;
  logic [3:0]             push_key;
  logic                   push, code_match;

  assign push = |push_vec;

  always_comb begin
    push_key = 4'(FIRST_LADDER);
    for (int j = NUM_LADDER - 1; j >= 0; j--) begin
      if (push_vec[j]) begin
        push_key = 4'(FIRST_LADDER + j);
      end
    end
  end

  always_comb begin
    code_match = &hist_vld_q;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (hist_q[i] != CODE_SEQ[i % 8]) begin
        code_match = 1'b0;
      end
    end
  end

  assign timer_sel = push ? tmo_q : timer_q;

  always_comb begin
    hist_d     = hist_q;
    hist_vld_d = hist_vld_q;
    timer_d    = timer_q;
    if (is_tick) begin
      if (push) begin
        for (int i = 0; i < CODE_LENGTH - 1; i++) begin
          hist_d[i]     = hist_q[i + 1];
          hist_vld_d[i] = hist_vld_q[i + 1];
        end
        hist_d[CODE_LENGTH - 1]     = push_key;
        hist_vld_d[CODE_LENGTH - 1] = 1'b1;
      end
      if (timer_sel == '0) begin
        hist_vld_d = '0;
        timer_d    = '0;
      end else begin
        timer_d = timer_sel - 16'd1;
      end
    end else if (exec && cmd == CMD_CHECK && code_match) begin
      hist_vld_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
      timer_q    <= TIMEOUT_RST;
    end else begin
      hist_vld_q <= hist_vld_d;
      timer_q    <= timer_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hist_q <= hist_d;
  end

  // result
  kdsc_key_sts_t sel_sts;
  logic [1:0]    act2;

  assign sel_sts = key_ok ? key_sts[key_idx]
                          : '{cur: LVL_NONE, stat: LVL_NONE, sp: LVL_NONE, press: 1'b0};
  assign act2    = {1'b0, act_vec[key_idx]};

  always_comb begin
    status_d = ST_OFF;
    case (cmd)
      CMD_TICK: status_d = ST_OFF;
      CMD_RD_STABLE: begin
        if (!key_ok || sel_sts.stat == LVL_NONE) begin
          status_d = ST_NONE;
        end else if (sel_sts.stat == act2) begin
          status_d = ST_ON;
        end else begin
          status_d = ST_OFF;
        end
      end
      CMD_RD_SHORT: status_d = (key_ok && sel_sts.sp == LVL_HIGH) ? ST_ON : ST_NONE;
      CMD_RD_CUR:   status_d = (key_ok && sel_sts.cur == act2) ? ST_ON : ST_OFF;
      CMD_CHECK:    status_d = code_match ? ST_ON : ST_OFF;
      default:      status_d = ST_OFF;
    endcase
  end

  `KDSC_ASSERT(a_exec_loads_out, exec |=> out_valid_q)
  `KDSC_ASSERT(a_s1_held, (s1_valid_q && !exec) |=> s1_valid_q)
  `KDSC_ASSERT(a_hist_contig, ((~hist_vld_q) & ((~hist_vld_q) + CODE_LENGTH'(1))) == '0)
  `KDSC_ASSERT_NEVER(a_multi_push, is_tick && !$onehot0(push_vec))

endmodule

@@ tb/tb_key_debounce_shortpress_combo.sv @@
`timescale 1ns / 100ps

module tb_key_debounce_shortpress_combo;
  import kdsc_pkg::*;

  localparam int unsigned KEY_COUNT   = 8;
  localparam int unsigned CODE_LEN    = 8;
  localparam int unsigned SHORT_LIMIT = 500;
  localparam int          CYCLE_LIMIT = 200000;

  localparam logic [2:0] CMD_MAX       = '1;
  // pin order {power, door, wall, ir}; wall is active low
  localparam logic [3:0] PINS_RELEASED = 4'b0010;
  localparam logic [3:0] PINS_POWER    = 4'b1010;

  typedef struct packed {
    logic [2:0] cmd;
    logic [2:0] key_id;
    logic [3:0] pins;
    logic [7:0] adc;
  } key_item_t;

  logic clk_i;
  logic rst_ni;

  kdsc_in_if  in_if ();
  kdsc_out_if res_if ();
  kdsc_cfg_if cfg_if ();

  key_debounce_shortpress_combo #(
    .NUM_KEYS         (KEY_COUNT),
    .CODE_LENGTH      (CODE_LEN),
    .SHORT_PRESS_LIMIT(SHORT_LIMIT)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // key state mirror
  logic [7:0]  deb_r, pwr_r;
  logic [7:0]  lvl_r [4];
  logic [6:0]  win_r;
  logic [15:0] tout_r;
  logic [1:0]  cur_lvl   [KEY_COUNT];
  logic [1:0]  prev_lvl  [KEY_COUNT];
  logic [1:0]  stab_st   [KEY_COUNT];
  logic [1:0]  short_st  [KEY_COUNT];
  logic [7:0]  stab_cnt  [KEY_COUNT];
  logic [8:0]  press_dur [KEY_COUNT];
  logic [3:0]  hist      [CODE_LEN];
  logic        hist_vld  [CODE_LEN];
  logic [15:0] hist_timer;

  logic [1:0] status_q [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int query_pct     = 0;
  int stall_left    = 0;
  int items_sent    = 0;
  int err_cnt       = 0;
  int cycle_cnt     = 0;

  function automatic void clear_history();
    for (int i = 0; i < CODE_LEN; i++) begin
      hist[i]     = '0;
      hist_vld[i] = 1'b0;
    end
  endfunction

  function automatic void keys_reset();
    deb_r    = DEBOUNCE_RST;
    pwr_r    = PWR_DEB_RST;
    lvl_r[0] = LVL_ONE_RST;
    lvl_r[1] = LVL_TWO_RST;
    lvl_r[2] = LVL_THR_RST;
    lvl_r[3] = LVL_FOUR_RST;
    win_r    = WINDOW_RST;
    tout_r   = TIMEOUT_RST;
    for (int k = 0; k < KEY_COUNT; k++) begin
      cur_lvl[k]   = LVL_NONE;
      prev_lvl[k]  = LVL_NONE;
      stab_st[k]   = LVL_NONE;
      short_st[k]  = LVL_NONE;
      stab_cnt[k]  = '0;
      press_dur[k] = '0;
    end
    clear_history();
    hist_timer = tout_r;
  endfunction

  function automatic int ladder_hit(logic [7:0] adc);
    for (int k = 0; k < NUM_LADDER; k++) begin
      if (int'(adc) <= int'(lvl_r[k]) + int'(win_r) &&
          int'(adc) >= int'(lvl_r[k]) - int'(win_r))
        return k;
    end
    return -1;
  endfunction

  function automatic void scan_tick(logic [3:0] pins, logic [7:0] adc);
    logic [1:0] smp [KEY_COUNT];
    logic [1:0] act;
    logic [7:0] lim;
    int hit;
    for (int k = 0; k < KEY_COUNT; k++) smp[k] = LVL_HIGH;
    for (int k = 0; k < 4; k++) smp[k] = {1'b0, pins[k]};
    hit = ladder_hit(adc);
    if (hit >= 0) smp[FIRST_LADDER + hit] = LVL_LOW;
    for (int k = 0; k < KEY_COUNT; k++) begin
      lim = (k == POWER_KEY) ? pwr_r : deb_r;
      act = {1'b0, ACT_LVL[k]};
      cur_lvl[k] = smp[k];
      if (short_st[k] == LVL_LOW) begin
        if (press_dur[k] < SHORT_LIMIT) press_dur[k]++;
        else short_st[k] = LVL_NONE;
      end
      if (cur_lvl[k] != prev_lvl[k]) begin
        stab_cnt[k] = '0;
        stab_st[k]  = LVL_NONE;
      end else if (stab_cnt[k] < lim) begin
        stab_cnt[k]++;
      end else if (stab_cnt[k] == lim) begin
        stab_st[k] = cur_lvl[k];
        stab_cnt[k]++;
        if (stab_st[k] == act) begin
          if (k >= FIRST_LADDER) begin
            hist_timer = tout_r;
            for (int i = 0; i < CODE_LEN - 1; i++) begin
              hist[i]     = hist[i + 1];
              hist_vld[i] = hist_vld[i + 1];
            end
            hist[CODE_LEN - 1]     = 4'(k);
            hist_vld[CODE_LEN - 1] = 1'b1;
          end
          press_dur[k] = '0;
          short_st[k]  = LVL_LOW;
        end else if (press_dur[k] < SHORT_LIMIT && short_st[k] == LVL_LOW) begin
          short_st[k] = LVL_HIGH;
        end
      end
      prev_lvl[k] = cur_lvl[k];
    end
    if (hist_timer == '0) clear_history();
    else hist_timer--;
  endfunction

  function automatic logic [1:0] predict_status(key_item_t it);
    logic [1:0] st;
    logic [1:0] act;
    bit         match;
    int         k;
    k   = it.key_id;
    act = {1'b0, ACT_LVL[k]};
    st  = ST_OFF;
    case (it.cmd)
      CMD_TICK: begin
        scan_tick(it.pins, it.adc);
      end
      CMD_RD_STABLE: begin
        if (stab_st[k] == act) begin
          stab_st[k] = LVL_NONE;
          st = ST_ON;
        end else if (stab_st[k] == LVL_NONE) begin
          st = ST_NONE;
        end else begin
          stab_st[k] = LVL_NONE;
        end
      end
      CMD_RD_SHORT: begin
        st = ST_NONE;
        if (short_st[k] == LVL_HIGH) begin
          short_st[k] = LVL_NONE;
          st = ST_ON;
        end
      end
      CMD_RD_CUR: begin
        if (cur_lvl[k] == act) st = ST_ON;
      end
      CMD_CHECK: begin
        match = 1'b1;
        for (int i = 0; i < CODE_LEN; i++)
          if (!hist_vld[i] || hist[i] != CODE_SEQ[i % 8]) match = 1'b0;
        if (match) begin
          clear_history();
          st = ST_ON;
        end
      end
      default: ;
    endcase
    return st;
  endfunction

  function automatic logic [7:0] adc_for_key(int k);
    int lo, hi, a;
    lo = int'(lvl_r[k]) - int'(win_r);
    hi = int'(lvl_r[k]) + int'(win_r);
    if (lo < 0) lo = 0;
    if (hi > 255) hi = 255;
    for (int n = 0; n < 16; n++) begin
      a = $urandom_range(hi, lo);
      if (ladder_hit(8'(a)) == k) return 8'(a);
    end
    for (a = lo; a <= hi; a++)
      if (ladder_hit(8'(a)) == k) return 8'(a);
    return lvl_r[k];
  endfunction

  function automatic logic [7:0] adc_idle();
    logic [7:0] a;
    for (int n = 0; n < 16; n++) begin
      a = 8'($urandom_range(255));
      if (ladder_hit(a) < 0) return a;
    end
    for (int v = 0; v < 256; v++)
      if (ladder_hit(8'(v)) < 0) return 8'(v);
    return 8'($urandom_range(255));
  endfunction

  function automatic key_item_t random_query();
    key_item_t it;
    int sel;
    it.key_id = 3'($urandom_range(7));
    it.pins   = 4'($urandom_range(15));
    it.adc    = 8'($urandom_range(255));
    sel       = $urandom_range(99);
    if (sel < 30) it.cmd = CMD_RD_STABLE;
    else if (sel < 55) it.cmd = CMD_RD_SHORT;
    else if (sel < 80) it.cmd = CMD_RD_CUR;
    else if (sel < 95) it.cmd = CMD_CHECK;
    else it.cmd = 3'($urandom_range(CMD_MAX, CMD_CHECK + 1));
    return it;
  endfunction

  // entered and left at a falling edge; valid stays high for back-to-back items
  task automatic send_item(input key_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.cmd        <= it.cmd;
    in_if.key_id     <= it.key_id;
    in_if.pin_ir     <= it.pins[0];
    in_if.pin_wall   <= it.pins[1];
    in_if.pin_door   <= it.pins[2];
    in_if.pin_power  <= it.pins[3];
    in_if.adc_sample <= it.adc;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    status_q.push_back(predict_status(it));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_tick(input logic [3:0] pins, input logic [7:0] adc);
    key_item_t it;
    it.cmd    = CMD_TICK;
    it.key_id = 3'($urandom_range(7));
    it.pins   = pins;
    it.adc    = adc;
    send_item(it);
  endtask

  task automatic send_query(input logic [2:0] cmd, input logic [2:0] key_id);
    key_item_t it;
    it        = random_query();
    it.cmd    = cmd;
    it.key_id = key_id;
    send_item(it);
  endtask

  task automatic hold_input(input logic [3:0] pins, input logic [7:0] adc, input int n);
    for (int t = 0; t < n; t++) begin
      if ($urandom_range(99) < query_pct) send_item(random_query());
      send_tick(pins, adc);
    end
  endtask

  task automatic press_ladder(input int k);
    logic [3:0] pins;
    pins = 4'($urandom_range(15));
    hold_input(pins, adc_for_key(k), deb_r + 1 + $urandom_range(2));
    hold_input(pins, adc_idle(), deb_r + 1 + $urandom_range(2));
  endtask

  task automatic cfg_write(input kdsc_reg_e idx, input logic [15:0] val);
    cfg_if.valid   <= 1'b1;
    cfg_if.reg_idx <= idx;
    cfg_if.wdata   <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      REG_DEBOUNCE:  deb_r    = val[7:0];
      REG_PWR_DEB:   pwr_r    = val[7:0];
      REG_LVL_ONE:   lvl_r[0] = val[7:0];
      REG_LVL_TWO:   lvl_r[1] = val[7:0];
      REG_LVL_THREE: lvl_r[2] = val[7:0];
      REG_LVL_FOUR:  lvl_r[3] = val[7:0];
      REG_WINDOW:    win_r    = val[6:0];
      REG_TIMEOUT:   tout_r   = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_regs(input logic [15:0] deb, input logic [15:0] pwr,
                          input logic [15:0] l1, input logic [15:0] l2,
                          input logic [15:0] l3, input logic [15:0] l4,
                          input logic [15:0] win, input logic [15:0] tout);
    cfg_write(REG_DEBOUNCE, deb);
    cfg_write(REG_PWR_DEB, pwr);
    cfg_write(REG_LVL_ONE, l1);
    cfg_write(REG_LVL_TWO, l2);
    cfg_write(REG_LVL_THREE, l3);
    cfg_write(REG_LVL_FOUR, l4);
    cfg_write(REG_WINDOW, win);
    cfg_write(REG_TIMEOUT, tout);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_reset_state();
    query_pct = 0;
    send_query(CMD_CHECK, 3'($urandom_range(7)));
    send_query(3'($urandom_range(CMD_MAX, CMD_CHECK + 1)), 3'($urandom_range(7)));
    send_query(CMD_RD_STABLE, 3'(0));
    send_query(CMD_RD_SHORT, 3'(KEY_COUNT - 1));
    send_query(CMD_RD_CUR, 3'(POWER_KEY));
  endtask

  task automatic test_field_extremes();
    send_tick('1, '1);
    send_tick('0, '0);
    send_query(CMD_RD_CUR, 3'(0));
  endtask

  task automatic test_short_press();
    for (int t = 0; t < int'(pwr_r) + 2; t++) send_tick(PINS_POWER, adc_idle());
    for (int t = 0; t < int'(pwr_r) + 2; t++) send_tick(PINS_RELEASED, adc_idle());
    send_query(CMD_RD_SHORT, 3'(POWER_KEY));
    send_query(CMD_RD_SHORT, 3'(POWER_KEY));
  endtask

  // press length straddles the short-press limit
  task automatic test_long_press();
    query_pct = 20;
    hold_input(PINS_POWER, adc_idle(),
               $urandom_range(SHORT_LIMIT + 6, SHORT_LIMIT - 6));
    hold_input(PINS_RELEASED, adc_idle(), int'(pwr_r) + 3);
    send_query(CMD_RD_SHORT, 3'(POWER_KEY));
  endtask

  task automatic test_random_keys(input int n);
    int stop_at, hold, mode;
    logic [3:0] pins;
    logic [7:0] adc;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pins = 4'($urandom_range(15));
      mode = $urandom_range(3);
      if (mode == 0) adc = 8'($urandom_range(255));
      else if (mode == 1) adc = adc_idle();
      else adc = adc_for_key($urandom_range(NUM_LADDER - 1));
      if ($urandom_range(9) < 7) hold = int'(deb_r) + 1 + $urandom_range(3);
      else hold = $urandom_range(int'(deb_r) + 1, 1);
      hold_input(pins, adc, hold);
    end
  endtask

  task automatic test_combo_code(input int rounds);
    bit add_fault;
    for (int r = 0; r < rounds; r++) begin
      add_fault = 1'($urandom_range(1));
      for (int i = 0; i < CODE_LEN; i++) begin
        if (add_fault && $urandom_range(7) == 0) press_ladder($urandom_range(NUM_LADDER - 1));
        press_ladder(int'(CODE_SEQ[i % 8]) - int'(FIRST_LADDER));
        if (tout_r < 16'd64 && $urandom_range(9) == 0)
          hold_input(PINS_RELEASED, adc_idle(), int'(tout_r) + 2);
      end
      send_query(CMD_CHECK, 3'($urandom_range(7)));
      send_query(CMD_CHECK, 3'($urandom_range(7)));
    end
  endtask

  task automatic test_backpressure();
    stall_left = 60;
    hold_input(4'($urandom_range(15)), 8'($urandom_range(255)), 20);
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    logic [1:0] want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (status_q.size() == 0) begin
        err_cnt++;
        $error("status: unexpected item, got %0d", res_if.status);
      end else begin
        want = status_q.pop_front();
        if (res_if.status !== want) begin
          err_cnt++;
          $error("status: expected %0d, got %0d", want, res_if.status);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_TICK;
    in_if.key_id     = '0;
    in_if.pin_ir     = 1'b0;
    in_if.pin_wall   = 1'b0;
    in_if.pin_door   = 1'b0;
    in_if.pin_power  = 1'b0;
    in_if.adc_sample = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_idx   = REG_DEBOUNCE;
    cfg_if.wdata     = '0;
    res_if.ready     = 1'b0;
    keys_reset();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 36;
    recv_idle_pct = 62;
    test_reset_state();
    test_field_extremes();
    test_short_press();
    test_long_press();

    wait_idle();
    set_regs(2, 0, 32, 96, 160, 224, 16, 16'hFFFF);
    test_random_keys(40);
    test_combo_code(2);

    wait_idle();
    send_idle_pct = 62;
    recv_idle_pct = 36;
    set_regs(0, 254, 0, 255, 128, 64, 0, 0);
    test_random_keys(40);
    test_combo_code(1);

    wait_idle();
    set_regs(254, 1, 40, 90, 140, 200, 127, 300);
    test_random_keys(60);

    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(1, 3, 32, 96, 160, 224, 20, 12);
    test_combo_code(2);
    test_backpressure();
    test_random_keys(40);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
